// ----- rtl/core/sba_pkg.sv -----
`default_nettype none
package sba_pkg;

    localparam int unsigned Width = 8;
    localparam int unsigned ValueWidth = 2 * Width;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [Width-1:0] operand_a;
        logic signed [Width-1:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value;
        logic signed [Width-1:0]      remainder;
        logic                         overflow;
        logic                         divide_by_zero;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        t_mode                   mode;
        logic [Width-1:0]        mag_a;
        logic [Width-1:0]        mag_b;
        logic                    neg_q;
        logic                    neg_r;
        logic signed [Width-1:0] sum;
        logic                    overflow;
        logic                    divide_by_zero;
    } t_work;

    // one pipeline step of multiply or divide
    typedef struct packed {
        logic                    vld;
        t_work                   w;
        logic [ValueWidth-1:0]   acc;
        logic [Width-1:0]        rem;
        logic [Width-1:0]        quo;
    } t_stage;

endpackage
`default_nettype wire

// ----- rtl/core/sba_front.sv -----
`default_nettype none
module sba_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sba_pkg::t_in_item i_in_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output sba_pkg::t_work         o_work,
    output logic                   o_work_valid,
    input  wire logic              i_work_ready
);

    sba_pkg::t_work w;
    logic [sba_pkg::Width-1:0] ua;
    logic [sba_pkg::Width-1:0] ub;
    logic [sba_pkg::Width-1:0] ob;
    logic [sba_pkg::Width-1:0] s;
    logic sa;
    logic sb;

    always_comb begin
        ua = i_in_data.operand_a;
        ub = i_in_data.operand_b;
        sa = ua[sba_pkg::Width-1];
        sb = ub[sba_pkg::Width-1];
        ob = (i_in_data.mode == sba_pkg::MODE_SUB) ? (~ub + 1'b1) : ub;
        s  = ua + ob;
        w = '0;
        w.mode  = sba_pkg::t_mode'(i_in_data.mode);
        w.mag_a = sa ? (~ua + 1'b1) : ua;
        w.mag_b = sb ? (~ub + 1'b1) : ub;
        w.neg_q = sa ^ sb;
        w.neg_r = sa;
        w.sum   = s;
        unique case (w.mode)
            sba_pkg::MODE_ADD: w.overflow = (sa == sb) && (s[sba_pkg::Width-1] != sa);
            sba_pkg::MODE_SUB: w.overflow = (sa != sb) && (s[sba_pkg::Width-1] != sa);
            sba_pkg::MODE_MUL: w.overflow = 1'b0;
            sba_pkg::MODE_DIV: w.overflow = (ua == {1'b1, {(sba_pkg::Width-1){1'b0}}})
                                            && (ub == '1);
            default: w.overflow = 1'b0;
        endcase
        w.divide_by_zero = (w.mode == sba_pkg::MODE_DIV) && (ub == '0);
    end

    // two-entry queue between front and back
    sba_pkg::t_work r_q [sba_pkg::QueueDepth];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       push;
    logic       pop;

    assign o_in_ready   = (r_cnt != 2'(sba_pkg::QueueDepth));
    assign push         = i_in_valid && o_in_ready;
    assign o_work_valid = (r_cnt != '0);
    assign pop          = o_work_valid && i_work_ready;
    assign o_work       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= w;
        end
    end

    property p_no_overfill;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(sba_pkg::QueueDepth);
    endproperty
    a_no_overfill: assert property (p_no_overfill) else $error("queue overfilled");

    property p_cnt_track;
        @(posedge i_clk) disable iff (!i_rst_n)
            (push && !pop) |=> (r_cnt == $past(r_cnt) + 2'd1);
    endproperty
    a_cnt_track: assert property (p_cnt_track) else $error("queue count slip");

    property p_dz_div;
        @(posedge i_clk) disable iff (!i_rst_n)
            w.divide_by_zero |-> (w.mode == sba_pkg::MODE_DIV) && !w.overflow;
    endproperty
    a_dz_div: assert property (p_dz_div) else $error("bad divide flags");

endmodule
`default_nettype wire

// ----- rtl/core/sba_back.sv -----
`default_nettype none
module sba_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sba_pkg::t_work     i_work,
    input  wire logic               i_work_valid,
    output logic                    o_work_ready,
    output sba_pkg::t_out_item      o_out_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready
);

    localparam int unsigned W = sba_pkg::Width;
    localparam int unsigned VW = sba_pkg::ValueWidth;

    // stage 0 holds the entry; stages 1..W each do one multiply/divide step
    sba_pkg::t_stage r_st [W+1];
    sba_pkg::t_stage n_st [W+1];
    logic            adv;
    sba_pkg::t_out_item fin;
    sba_pkg::t_out_item r_out;
    logic               r_out_vld;

    // whole pipe stalls together when the output register is held
    assign adv          = !r_out_vld || i_out_ready;
    assign o_work_ready = adv;

    always_comb begin
        logic [W:0]   trial;
        logic [W-1:0] rsh;
        n_st[0].vld = i_work_valid;
        n_st[0].w   = i_work;
        n_st[0].acc = '0;
        n_st[0].rem = '0;
        n_st[0].quo = '0;
        for (int k = 1; k <= W; k++) begin
            n_st[k] = r_st[k-1];
            if (r_st[k-1].w.mag_b[k-1]) begin
                n_st[k].acc = r_st[k-1].acc + (VW'(r_st[k-1].w.mag_a) << (k-1));
            end
            rsh   = {r_st[k-1].rem[W-2:0], r_st[k-1].w.mag_a[W-k]};
            trial = {r_st[k-1].rem[W-1], rsh} - {1'b0, r_st[k-1].w.mag_b};
            if (!trial[W]) begin
                n_st[k].rem = trial[W-1:0];
                n_st[k].quo = {r_st[k-1].quo[W-2:0], 1'b1};
            end else begin
                n_st[k].rem = rsh;
                n_st[k].quo = {r_st[k-1].quo[W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        sba_pkg::t_stage l;
        l = r_st[W];
        fin = '0;
        fin.overflow       = l.w.overflow;
        fin.divide_by_zero = l.w.divide_by_zero;
        unique case (l.w.mode)
            sba_pkg::MODE_ADD, sba_pkg::MODE_SUB: fin.value = VW'(l.w.sum);
            sba_pkg::MODE_MUL: fin.value = l.w.neg_q ? (~l.acc + 1'b1) : l.acc;
            sba_pkg::MODE_DIV: begin
                if (!l.w.divide_by_zero) begin
                    fin.value = l.w.neg_q ? (~VW'(l.quo) + 1'b1) : VW'(l.quo);
                    fin.remainder = l.w.neg_r ? (~l.rem + 1'b1) : l.rem;
                end
            end
            default: fin.value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) begin
                r_st[k].vld <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (adv) begin
            for (int k = 0; k <= W; k++) begin
                r_st[k] <= n_st[k];
            end
            r_out_vld <= r_st[W].vld;
            r_out     <= fin;
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_vld;

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_vld && !i_out_ready) |=> r_out_vld && $stable(r_out);
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped while stalled");

    property p_remz;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_out_vld && r_out.divide_by_zero) |-> (r_out.value == '0);
    endproperty
    a_remz: assert property (p_remz) else $error("nonzero value on divide by zero");

    property p_adv;
        @(posedge i_clk) disable iff (!i_rst_n)
            (adv && r_st[W].vld) |=> r_out_vld;
    endproperty
    a_adv: assert property (p_adv) else $error("pipe exit lost");

endmodule
`default_nettype wire

// ----- rtl/core/signed_byte_alu_core.sv -----
// Pipeline: an accepted request passes the two-entry queue, then entry, 8 steps, out reg.
// Throughput: one request per cycle while the output is not held; multiply and divide are fully pipelined.
// A held output stalls the whole back pipeline; the two-entry queue absorbs it.
// Reset: synchronous, active low on i_rst_n; clears queue and pipeline valid bits.
`default_nettype none
module signed_byte_alu_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sba_pkg::t_in_item   i_in_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output sba_pkg::t_out_item       o_out_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready
);

    sba_pkg::t_work work;
    logic           work_valid;
    logic           work_ready;

    sba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .o_work       (work),
        .o_work_valid (work_valid),
        .i_work_ready (work_ready)
    );

    sba_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (work),
        .i_work_valid (work_valid),
        .o_work_ready (work_ready),
        .o_out_data   (o_out_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

endmodule
`default_nettype wire
